// ----- src/sha_pkg.sv -----
// Shared types and constants for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;       // load initial hash, clear counts
        logic wr_byte;    // store the input byte at the byte count
        logic pad_start;  // begin padding: store 0x80, latch total length
        logic pad_zero;   // write a zero byte at the pad pointer
        logic pad_len;    // write the length bytes into the tail
        logic blk_clear;  // clear the whole block buffer
        logic round_load; // copy hash into working variables, round zero
        logic round_step; // perform one round
        logic hash_add;   // add working variables into the hash
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_full; // the byte count is 63 (next byte completes block)
        logic pad_tail;   // pad pointer wrapped round to 0 (byte 63 written)
        logic pad_two;    // padding needs two blocks
        logic round_last; // round counter at 63
    } t_dp_sts;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- src/sha_dp.sv -----
// Datapath of the SHA-256 hasher: block buffer, counters, schedule and rounds.
`timescale 1ns / 1ps
module sha_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_byte,
    output sha_pkg::t_dp_sts  o_sts,
    output logic [31:0]       o_hash [8]
);
    import sha_pkg::*;

    logic [31:0] r_hash [8];
    logic [31:0] r_blk [16];
    logic [5:0]  r_cnt;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic [5:0]  r_pad;
    logic        r_two;
    logic [5:0]  r_rnd;
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];

    logic [31:0] n_w_new;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;

    // During rounds 0..15 the message words come from the buffer; after
    // that from a 16-word sliding window.
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        n_w_new = s1 + r_w[9] + s0 + r_w[0];
        if (r_rnd < 6'd16) begin
            w_cur = r_blk[r_rnd[3:0]];
        end else begin
            w_cur = n_w_new;
        end
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K[r_rnd] + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_hash[i] <= H_INIT[i];
            r_cnt  <= '0;
            r_bits <= '0;
            r_rnd  <= '0;
        end else begin
            if (i_cmd.init) begin
                for (int i = 0; i < 8; i++) r_hash[i] <= H_INIT[i];
                r_cnt  <= '0;
                r_bits <= '0;
            end
            if (i_cmd.wr_byte) begin
                r_blk[r_cnt[5:2]][{~r_cnt[1:0], 3'd0} +: 8] <= i_byte;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) r_bits <= r_bits + BLOCK_BITS;
            end
            if (i_cmd.pad_start) begin
                r_blk[r_cnt[5:2]][{~r_cnt[1:0], 3'd0} +: 8] <= PAD_BYTE;
                r_pad   <= r_cnt + 6'd1;
                r_two   <= (r_cnt >= 6'd56);
                r_total <= r_bits + {55'd0, r_cnt, 3'd0};
            end
            if (i_cmd.pad_zero) begin
                r_blk[r_pad[5:2]][{~r_pad[1:0], 3'd0} +: 8] <= 8'd0;
                r_pad <= r_pad + 6'd1;
            end
            if (i_cmd.pad_len) begin
                r_blk[14] <= r_total[63:32];
                r_blk[15] <= r_total[31:0];
                r_two <= 1'b0;
                r_pad <= '0;
            end
            if (i_cmd.blk_clear) begin
                for (int i = 0; i < 16; i++) r_blk[i] <= '0;
            end
            if (i_cmd.round_load) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_hash[i];
                r_rnd <= '0;
            end
            if (i_cmd.round_step) begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_cur;
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.hash_add) begin
                for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    assign o_sts.block_full = (r_cnt == 6'd63);
    assign o_sts.pad_tail   = (r_pad == 6'd0);
    assign o_sts.pad_two    = r_two;
    assign o_sts.round_last = (r_rnd == 6'd63);
    assign o_hash = r_hash;

endmodule

// ----- src/sha_ctrl.sv -----
// Controller of the SHA-256 hasher: command decode, sequencing and output.
`timescale 1ns / 1ps
module sha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha_pkg::t_in_item   i_data,
    input  sha_pkg::t_dp_sts    i_sts,
    input  logic [31:0]         i_hash [8],
    output sha_pkg::t_dp_cmd    o_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output sha_pkg::t_out_item  o_data
);
    import sha_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_ROUND = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_ZERO  = 7'b0010000,
        S_LEN   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_fin, n_fin;
    logic [2:0] r_idx, n_idx;
    logic       acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;
    assign o_valid = (r_state == S_EMIT);
    assign o_data.digest_word = i_hash[r_idx];
    assign o_data.word_index  = r_idx;
    assign o_data.last_word   = (r_idx == 3'd7);

    always_comb begin
        n_state = r_state;
        n_fin = r_fin;
        n_idx = r_idx;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (t_cmd'(i_data.command))
                        CMD_START: o_cmd.init = 1'b1;
                        CMD_APPEND: begin
                            o_cmd.wr_byte = 1'b1;
                            if (i_sts.block_full) begin
                                n_fin = 1'b0;
                                n_state = S_LOAD;
                            end
                        end
                        CMD_FINISH: begin
                            o_cmd.pad_start = 1'b1;
                            n_fin = 1'b1;
                            n_state = S_ZERO;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ZERO: begin
                if (i_sts.pad_tail) begin
                    n_state = i_sts.pad_two ? S_LOAD : S_LEN;
                end else begin
                    o_cmd.pad_zero = 1'b1;
                end
            end
            S_LEN: begin
                o_cmd.pad_len = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.round_load = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (i_sts.round_last) n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.hash_add = 1'b1;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (i_sts.pad_two) begin
                    o_cmd.blk_clear = 1'b1;
                    n_state = S_LEN;
                end else begin
                    n_idx = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.init = 1'b1;
                        n_fin = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_idx   <= n_idx;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr_byte, o_cmd.pad_start, o_cmd.pad_zero, o_cmd.pad_len,
                  o_cmd.round_load, o_cmd.round_step, o_cmd.hash_add}))
        else $error("conflicting datapath commands");
    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && r_idx != 3'd7 |=> o_valid && r_idx == $past(r_idx) + 3'd1)
        else $error("digest word order broken");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND && i_sts.round_last |=> r_state == S_ADD)
        else $error("round loop overran");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready)
        else $error("transfer accepted while busy");

endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
// Start, append and finish commands arrive as transfers; an append does not
// stall the input, except the 64th byte of a block, which holds off the input
// while the 64 rounds run through a single shared round unit. A finish pads
// one zero byte per cycle, runs one or two compressions and then offers the
// eight digest words, one per output transfer; the block returns to the
// start state after the last one.
module sha256_byte_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sha_pkg::t_out_item  o_data
);
    import sha_pkg::*;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] hash [8];

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .i_sts(sts), .i_hash(hash), .o_cmd(cmd),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    sha_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(i_data.data_byte),
        .o_sts(sts), .o_hash(hash)
    );

endmodule
